// File: hdl/nearest_blob_search_table_top_assert.svh
// Assertion macros used by the blob search table top level.
`ifndef NEAREST_BLOB_SEARCH_TABLE_TOP_ASSERT_SVH
`define NEAREST_BLOB_SEARCH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on aclk, held off during reset.
`define NBST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, held off during reset.
`define NBST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/nbst_pkg.sv
// Shared types and constants of the blob search table.
package nbst_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COORD_W         = 16;
    localparam int KIND_W          = 2;
    localparam int IDX_OUT_W       = 6;
    localparam int S_TDATA_W       = 5 * COORD_W;
    localparam int M_TDATA_W       = 8;
    localparam int SQ_W            = 2 * COORD_W;
    localparam int DIST_W          = SQ_W + 1;

    localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSEST   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PRECISION = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] spread_y;
        logic [COORD_W-1:0] spread_x;
        logic [COORD_W-1:0] centre_y;
        logic [COORD_W-1:0] centre_x;
    } nbst_entry_t;

    typedef struct packed {
        logic               busy;
        logic               have;
        logic [COORD_W-1:0] best_dx;
        logic [COORD_W-1:0] best_dy;
    } nbst_scan_status_t;

endpackage

// File: hdl/nbst_scan.sv
// Distance pipeline and running best-match tracker for the table scan.
module nbst_scan #(
    parameter int AW = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        use_reach,
    input  logic [nbst_pkg::COORD_W-1:0] qx,
    input  logic [nbst_pkg::COORD_W-1:0] qy,
    input  logic                        in_vld,
    input  logic [AW-1:0]               in_idx,
    input  nbst_pkg::nbst_entry_t       in_entry,
    output nbst_pkg::nbst_scan_status_t status,
    output logic [AW-1:0]               best_idx
);
    import nbst_pkg::*;

    // stage 1: axis offsets and larger spread
    logic               s1_vld_reg;
    logic [AW-1:0]      s1_idx_reg;
    logic [COORD_W-1:0] s1_dx_reg, s1_dy_reg, s1_r_reg;
    // stage 2: squares
    logic               s2_vld_reg;
    logic [AW-1:0]      s2_idx_reg;
    logic [COORD_W-1:0] s2_dx_reg, s2_dy_reg;
    logic [SQ_W-1:0]    s2_dx2_reg, s2_dy2_reg, s2_r2_reg;
    // stage 3: squared distance
    logic               s3_vld_reg;
    logic [AW-1:0]      s3_idx_reg;
    logic [COORD_W-1:0] s3_dx_reg, s3_dy_reg;
    logic [SQ_W-1:0]    s3_r2_reg;
    logic [DIST_W-1:0]  s3_d_reg;
    // best so far
    logic               have_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [COORD_W-1:0] best_dx_reg, best_dy_reg;

    logic [COORD_W-1:0] dx, dy, r;
    logic               in_reach, better, take;

    always_comb begin
        dx = (in_entry.centre_x >= qx) ? in_entry.centre_x - qx : qx - in_entry.centre_x;
        dy = (in_entry.centre_y >= qy) ? in_entry.centre_y - qy : qy - in_entry.centre_y;
        r  = (in_entry.spread_x > in_entry.spread_y) ? in_entry.spread_x : in_entry.spread_y;
        in_reach = !use_reach || ({1'b0, s3_r2_reg} >= s3_d_reg);
        better   = !have_reg || (s3_d_reg < best_d_reg);
        take     = s3_vld_reg && in_reach && better;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            have_reg   <= 1'b0;
        end else begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (start) begin
                have_reg <= 1'b0;
            end else if (take) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg <= in_idx;
        s1_dx_reg  <= dx;
        s1_dy_reg  <= dy;
        s1_r_reg   <= r;

        s2_idx_reg <= s1_idx_reg;
        s2_dx_reg  <= s1_dx_reg;
        s2_dy_reg  <= s1_dy_reg;
        s2_dx2_reg <= s1_dx_reg * s1_dx_reg;
        s2_dy2_reg <= s1_dy_reg * s1_dy_reg;
        s2_r2_reg  <= s1_r_reg * s1_r_reg;

        s3_idx_reg <= s2_idx_reg;
        s3_dx_reg  <= s2_dx_reg;
        s3_dy_reg  <= s2_dy_reg;
        s3_r2_reg  <= s2_r2_reg;
        s3_d_reg   <= {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};

        if (take) begin
            best_d_reg   <= s3_d_reg;
            best_idx_reg <= s3_idx_reg;
            best_dx_reg  <= s3_dx_reg;
            best_dy_reg  <= s3_dy_reg;
        end
    end

    assign status.busy    = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign status.have    = have_reg;
    assign status.best_dx = best_dx_reg;
    assign status.best_dy = best_dy_reg;
    assign best_idx       = best_idx_reg;

endmodule

// File: hdl/nearest_blob_search_table_top.sv
// Top level of the nearest blob search table.
//
// Input channel (s_): one beat is one command. s_tuser carries the kind (clear, append,
// closest within spread, closest within precision); s_tdata carries the coordinates.
// Result channel (m_): exactly one beat per command, in command order, carrying
// found, match_index and dropped.
// Clear and append skip the scan and go straight to the result state. A query reads the
// entry memory one entry per cycle through a single read port, then waits for the
// distance pipeline behind that port to drain before it answers; on an empty table
// it reads no entries.
// One command is in work at a time; a finished result waits in the output register,
// so the next command is accepted while the receiver stalls. A second result waits
// until the output register is taken.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// the entry memory is not cleared, since only entries below the count are read.
// An append to a full table leaves the table alone and answers dropped.
module nearest_blob_search_table_top #(
    parameter int MAX_ENTRIES = nbst_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] spread_x, [63:48] spread_y, [79:64] precision
    input  logic [nbst_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [nbst_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] found, [6:1] match_index, [7] dropped
    output logic [nbst_pkg::M_TDATA_W-1:0]  m_tdata
);
    import nbst_pkg::*;

`include "nearest_blob_search_table_top_assert.svh"

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [COORD_W-1:0]  qx_reg, qy_reg, prec_reg;
    logic                res_found_reg, res_dropped_reg;
    logic [IDX_OUT_W-1:0] res_idx_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // entry memory, one synchronous read port
    nbst_entry_t         mem [MAX_ENTRIES];
    nbst_entry_t         rdata_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_idx_reg;

    nbst_entry_t         wr_entry;
    logic                accept, is_query, rd_en, wr_en, full, out_free, drain_done;
    logic                q_found;
    logic [AW-1:0]       best_idx;
    logic [IDX_OUT_W+AW-1:0] best_idx_ext;
    nbst_scan_status_t   status;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign is_query = (s_tuser == KIND_CLOSEST) || (s_tuser == KIND_PRECISION);
    assign full     = (count_reg == MAX_CNT);
    assign wr_en    = accept && (s_tuser == KIND_APPEND) && !full;
    assign rd_en    = (state_reg == S_SCAN) && (scan_idx_reg != count_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign drain_done = !rd_vld_reg && !status.busy;

    assign wr_entry.centre_x = s_tdata[15:0];
    assign wr_entry.centre_y = s_tdata[31:16];
    assign wr_entry.spread_x = s_tdata[47:32];
    assign wr_entry.spread_y = s_tdata[63:48];

    // Writes only happen at acceptance and reads only during a later scan, so the
    // single port never sees a write and read of the same entry in one cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= wr_entry;
        end
        if (rd_en) begin
            rdata_reg <= mem[scan_idx_reg[AW-1:0]];
        end
        rd_idx_reg <= scan_idx_reg[AW-1:0];
    end

    nbst_scan #(
        .AW (AW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && is_query),
        .use_reach (kind_reg == KIND_CLOSEST),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .in_vld    (rd_vld_reg),
        .in_idx    (rd_idx_reg),
        .in_entry  (rdata_reg),
        .status    (status),
        .best_idx  (best_idx)
    );

    // precision query rejects the nearest entry when either offset reaches the limit
    always_comb begin
        best_idx_ext = {{IDX_OUT_W{1'b0}}, best_idx};
        q_found = status.have &&
                  ((kind_reg == KIND_CLOSEST) ||
                   ((status.best_dx < prec_reg) && (status.best_dy < prec_reg)));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = is_query ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (scan_idx_reg == count_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (accept && (s_tuser == KIND_CLEAR)) begin
                count_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + 1'b1;
            end
            if ((state_reg == S_RESULT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg        <= s_tuser;
            qx_reg          <= s_tdata[15:0];
            qy_reg          <= s_tdata[31:16];
            prec_reg        <= s_tdata[79:64];
            scan_idx_reg    <= '0;
            res_found_reg   <= 1'b0;
            res_idx_reg     <= '0;
            res_dropped_reg <= (s_tuser == KIND_APPEND) && full;
        end else if (rd_en) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if ((state_reg == S_DRAIN) && drain_done) begin
            res_found_reg <= q_found;
            res_idx_reg   <= q_found ? best_idx_ext[IDX_OUT_W-1:0] : '0;
        end
        if ((state_reg == S_RESULT) && out_free) begin
            m_tdata_reg <= {res_dropped_reg, res_idx_reg, res_found_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `NBST_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= MAX_CNT, "entry count above table depth")
    `NBST_ASSERT_NOW(a_read_in_range, rd_en, scan_idx_reg < count_reg, "scan read past count")
    `NBST_ASSERT_NEXT(a_append_grows, wr_en, count_reg == $past(count_reg) + 1'b1, "append lost")
    `NBST_ASSERT_NEXT(a_result_loads, (state_reg == S_RESULT) && out_free,
        m_tvalid_reg && (state_reg == S_IDLE), "result not presented")

endmodule

// File: tb/nbst_result_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares every result beat of the blob search table.
module nbst_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] spread_x, [63:48] spread_y, [79:64] precision
    input  logic [nbst_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [nbst_pkg::KIND_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] found, [6:1] match_index, [7] dropped
    input  logic [nbst_pkg::M_TDATA_W-1:0] m_tdata,
    output int unsigned                    fail_count,
    output int unsigned                    pending_count
);
    import nbst_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
        logic                 dropped;
    } blob_answer_t;

    // Own copy of the blob table.
    logic [COORD_W-1:0] table_x  [TABLE_DEPTH];
    logic [COORD_W-1:0] table_y  [TABLE_DEPTH];
    logic [COORD_W-1:0] table_sx [TABLE_DEPTH];
    logic [COORD_W-1:0] table_sy [TABLE_DEPTH];
    int unsigned        table_fill = 0;

    blob_answer_t answer_q[$];
    int unsigned  mismatch_total = 0;

    function automatic logic [COORD_W-1:0] offset_of(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Apply one command to the table copy and work out its answer.
    task automatic predict_answer(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] px,
                                  input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] sx,
                                  input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] prec,
                                  output blob_answer_t ans);
        logic [33:0] dx, dy, dist_sq, best_dist, reach, reach_sq;
        logic        have;
        int unsigned best;
        ans       = '0;
        have      = 1'b0;
        best      = 0;
        best_dist = '0;
        case (kind)
            KIND_CLEAR: begin
                table_fill = 0;
            end
            KIND_APPEND: begin
                if (table_fill < TABLE_DEPTH) begin
                    table_x[table_fill]  = px;
                    table_y[table_fill]  = py;
                    table_sx[table_fill] = sx;
                    table_sy[table_fill] = sy;
                    table_fill++;
                end else begin
                    ans.dropped = 1'b1;
                end
            end
            default: begin
                for (int unsigned i = 0; i < table_fill; i++) begin
                    dx       = offset_of(table_x[i], px);
                    dy       = offset_of(table_y[i], py);
                    dist_sq  = dx * dx + dy * dy;
                    reach    = (table_sx[i] > table_sy[i]) ? table_sx[i] : table_sy[i];
                    reach_sq = reach * reach;
                    if (kind != KIND_CLOSEST || reach_sq >= dist_sq) begin
                        if (!have || dist_sq < best_dist) begin
                            have      = 1'b1;
                            best_dist = dist_sq;
                            best      = i;
                        end
                    end
                end
                if (have) begin
                    if (kind == KIND_CLOSEST ||
                        (offset_of(table_x[best], px) < prec &&
                         offset_of(table_y[best], py) < prec)) begin
                        ans.found = 1'b1;
                        ans.index = best[IDX_OUT_W-1:0];
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string tag, input blob_answer_t want,
                                 input blob_answer_t got);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("[%0t] %s: expected found %0d index %0d dropped %0d, ",
                     $time, tag, want.found, want.index, want.dropped,
                     "got found %0d index %0d dropped %0d",
                     got.found, got.index, got.dropped);
        end
    endtask

    always @(posedge aclk) begin
        blob_answer_t want, got;
        if (!aresetn) begin
            answer_q.delete();
            table_fill = 0;
        end else begin
            // Compare a result beat with the oldest answer waiting.
            if (m_tvalid && m_tready) begin
                got.found   = m_tdata[0];
                got.index   = m_tdata[6:1];
                got.dropped = m_tdata[7];
                if (answer_q.size() == 0) begin
                    note_mismatch("result beat with nothing expected", '0, got);
                end else begin
                    want = answer_q.pop_front();
                    if (got.found !== want.found || got.index !== want.index ||
                        got.dropped !== want.dropped) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_answer(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                               s_tdata[63:48], s_tdata[79:64], want);
                answer_q = {answer_q, want};
            end
        end
        fail_count    <= mismatch_total;
        pending_count <= answer_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives commands into the blob search table and gives the verdict.
module testbench;
    import nbst_pkg::*;

    localparam int unsigned RUN_ITEMS    = 550;
    localparam int unsigned QUIET_ITEMS  = 60;     // tail of the run with no idling
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 80;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = KIND_CLEAR;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire  [M_TDATA_W-1:0]   m_tdata;

    int unsigned fail_count;
    int unsigned pending_count;

    bit          idle_on     = 1'b1;   // random idling on both sides
    bit          quiet       = 1'b0;   // set for the final stretch of the run
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    // Centres appended since the last clear, used to aim queries at stored blobs.
    logic [COORD_W-1:0] shadow_x[$];
    logic [COORD_W-1:0] shadow_y[$];

    nearest_blob_search_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nbst_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts while idling is on, else take every beat.
    always @(posedge aclk) begin
        if (!idle_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [COORD_W-1:0] rnd16();
        return 16'($urandom);
    endfunction

    // Move a coordinate by a random offset within +-span, clamped to the field range.
    function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] c,
                                                  input int unsigned span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return v[15:0];
    endfunction

    // Send one command beat; hold it until the block takes it.
    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] sx,
                            input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] prec);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prec, sy, sx, py, px};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        // Track the centres the table should now hold.
        if (kind == KIND_CLEAR) begin
            shadow_x.delete();
            shadow_y.delete();
        end else if (kind == KIND_APPEND && shadow_x.size() < MAX_ENTRIES_DEF) begin
            shadow_x = {shadow_x, px};
            shadow_y = {shadow_y, py};
        end
    endtask

    // Drop the input valid and wait until every expected result beat has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Append a blob near the cluster base, now and then on top of an earlier centre.
    task automatic send_blob(input logic [COORD_W-1:0] base_x, input logic [COORD_W-1:0] base_y);
        logic [COORD_W-1:0] cx, cy, sx, sy;
        int unsigned        pick;
        if (shadow_x.size() != 0 && $urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, shadow_x.size() - 1);
            cx   = shadow_x[pick];
            cy   = shadow_y[pick];
        end else begin
            cx = jitter(base_x, 255);
            cy = jitter(base_y, 255);
        end
        if ($urandom_range(0, 7) == 0) begin
            sx = rnd16();
            sy = rnd16();
        end else begin
            sx = 16'($urandom_range(0, 96));
            sy = 16'($urandom_range(0, 96));
        end
        send_cmd(KIND_APPEND, cx, cy, sx, sy, rnd16());
    endtask

    // Ask a query close to a stored centre so that reach and precision both go either way.
    task automatic send_query(input logic [KIND_W-1:0] kind);
        int unsigned        pick;
        logic [COORD_W-1:0] qx, qy, prec;
        if (shadow_x.size() == 0) begin
            qx = rnd16();
            qy = rnd16();
        end else begin
            pick = $urandom_range(0, shadow_x.size() - 1);
            qx   = jitter(shadow_x[pick], 40);
            qy   = jitter(shadow_y[pick], 40);
        end
        case ($urandom_range(0, 5))
            0:       prec = '0;
            1:       prec = rnd16();
            default: prec = 16'($urandom_range(1, 48));
        endcase
        send_cmd(kind, qx, qy, rnd16(), rnd16(), prec);
    endtask

    // Fill the table to the top, push a few appends past it, then query the full table.
    task automatic fill_table();
        logic [COORD_W-1:0] base_x, base_y;
        base_x = rnd16();
        base_y = rnd16();
        send_cmd(KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        repeat (MAX_ENTRIES_DEF + $urandom_range(1, 3)) send_blob(base_x, base_y);
        repeat (4) send_query($urandom_range(0, 1) ? KIND_CLOSEST : KIND_PRECISION);
    endtask

    // One random episode: mostly clear, a cluster of appends and aimed queries;
    // sometimes noise, a sequence without its clear, or a full-table run.
    task automatic run_episode();
        logic [COORD_W-1:0] base_x, base_y;
        int unsigned        pick;
        if (!quiet) begin
            idle_on <= ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            fill_table();
        end else if (pick <= 2) begin
            repeat (6) send_cmd(2'($urandom), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        end else begin
            base_x = rnd16();
            base_y = rnd16();
            if (pick != 3) begin
                send_cmd(KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            end
            repeat ($urandom_range(1, 12)) send_blob(base_x, base_y);
            repeat ($urandom_range(2, 8)) begin
                send_query($urandom_range(0, 1) ? KIND_CLOSEST : KIND_PRECISION);
            end
        end
    endtask

    initial begin
        // Hold reset low at the start, then release it once for the whole run.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queries on the empty table.
        send_cmd(KIND_CLOSEST,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_PRECISION, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Blobs at both corners of the field range.
        send_cmd(KIND_APPEND,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_APPEND,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Zero spread still reaches its own centre; far corner is out of reach.
        send_cmd(KIND_CLOSEST,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        // Precision zero never matches; offset equal to precision is rejected.
        send_cmd(KIND_PRECISION, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_PRECISION, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
        send_cmd(KIND_PRECISION, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
        // Duplicate centre: the tie goes to the lower index.
        send_cmd(KIND_APPEND,    16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Reach exactly on the larger spread (y larger), then one step beyond it.
        send_cmd(KIND_APPEND,    16'h0100, 16'h0100, 16'h0003, 16'h0004, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'h0104, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'h0104, 16'h0101, 16'h0000, 16'h0000, 16'h0000);
        // Same with x the larger spread.
        send_cmd(KIND_APPEND,    16'h0200, 16'h0200, 16'h0004, 16'h0003, 16'h0000);
        send_cmd(KIND_CLOSEST,   16'h0200, 16'h0204, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_PRECISION, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF);
        // Alternating bit patterns in every field.
        send_cmd(KIND_APPEND,    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_cmd(KIND_PRECISION, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA);
        // Clear forgets every blob.
        send_cmd(KIND_CLEAR,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(KIND_CLOSEST,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(KIND_PRECISION, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000, 16'hFFFF);

        // Pause the sender until every answer is back, then run the full table once.
        wait_for_drain();
        fill_table();

        while (items_sent < RUN_ITEMS - QUIET_ITEMS) run_episode();
        // Finish with no idling on either side.
        quiet = 1'b1;
        idle_on <= 1'b0;
        while (items_sent < RUN_ITEMS) run_episode();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
